### design/tcp_pkg.sv
// shared types, character codes and keyword tables for the timeout command parser
// no dependencies; compiled first
package tcp_pkg;

    localparam int BYTE_W      = 8;
    localparam int PHASE_W     = 3;
    localparam int POS_W       = 3;
    localparam int OUT_VALUE_W = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int DIGIT_W     = 4;

    localparam logic [BYTE_W-1:0] CH_BAR = 8'h7C;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_S   = 8'h53;
    localparam logic [BYTE_W-1:0] CH_E   = 8'h45;
    localparam logic [BYTE_W-1:0] CH_T   = 8'h54;
    localparam logic [BYTE_W-1:0] CH_I   = 8'h49;
    localparam logic [BYTE_W-1:0] CH_M   = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_O   = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_U   = 8'h55;

    localparam logic [POS_W-1:0] SET_LEN     = 3'd3;
    localparam logic [POS_W-1:0] TIMEOUT_LEN = 3'd7;

    typedef enum logic [PHASE_W-1:0] {
        PH_SET     = 3'd0,
        PH_TIMEOUT = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_LF      = 3'd3,
        PH_DONE    = 3'd4,
        PH_BAD     = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        logic [POS_W-1:0]  char_pos;
    } t_ctl;

    function automatic logic [BYTE_W-1:0] kw_set_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = CH_S;
            3'd1:    c = CH_E;
            default: c = CH_T;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_timeout_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = CH_T;
            3'd1:    c = CH_I;
            3'd2:    c = CH_M;
            3'd3:    c = CH_E;
            3'd4:    c = CH_O;
            3'd5:    c = CH_U;
            default: c = CH_T;
        endcase
        return c;
    endfunction

endpackage

### design/tcp_chan_if.sv
// valid/ready channel interfaces for command bytes in and parser status out
// depends on tcp_pkg for field widths
interface tcp_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcp_pkg::BYTE_W-1:0]   byte_in;
    logic                         restart;

    modport source (output valid, output byte_in, output restart, input ready);
    modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface tcp_out_if;
    logic                             valid;
    logic                             ready;
    logic [tcp_pkg::PHASE_W-1:0]      phase;
    logic [tcp_pkg::OUT_VALUE_W-1:0]  timeout_value;
    logic                             done_res;

    modport source (output valid, output phase, output timeout_value, output done_res,
                    input ready);
    modport sink   (input valid, input phase, input timeout_value, input done_res,
                    output ready);
endinterface

### design/tcp_step.sv
// next-state logic of the parser: keyword match, digit accumulate with saturation
// depends on tcp_pkg
module tcp_step #(
    parameter int VALUE_BITS = tcp_pkg::VALUE_BITS_DEF
) (
    input  tcp_pkg::t_ctl                      i_ctl,
    input  logic [VALUE_BITS-1:0]              i_accum,
    input  logic [tcp_pkg::BYTE_W-1:0]         i_byte,
    input  logic                               i_restart,
    output tcp_pkg::t_ctl                      o_ctl,
    output logic [VALUE_BITS-1:0]              o_accum,
    output logic [tcp_pkg::OUT_VALUE_W-1:0]    o_value
);
    import tcp_pkg::*;

    localparam int EXT_W = VALUE_BITS + DIGIT_W;

    logic [DIGIT_W-1:0] w_digit;
    logic [EXT_W-1:0]   w_ext;
    logic [EXT_W-1:0]   w_prod;
    logic               w_is_digit;

    assign w_digit    = DIGIT_W'(i_byte - CH_0);
    assign w_ext      = {{DIGIT_W{1'b0}}, i_accum};
    // accum*10 + digit, any carry into the top nibble means overflow
    assign w_prod     = (w_ext << 3) + (w_ext << 1) + EXT_W'(w_digit);
    assign w_is_digit = i_byte inside {[CH_0:CH_9]};

    always_comb begin
        o_ctl   = i_ctl;
        o_accum = i_accum;
        if (i_restart) begin
            o_ctl.phase    = PH_SET;
            o_ctl.char_pos = '0;
            o_accum        = '0;
        end else begin
            case (i_ctl.phase)
                PH_SET: begin
                    if (i_ctl.char_pos >= SET_LEN) begin
                        if (i_byte == CH_BAR) begin
                            o_ctl.phase    = PH_TIMEOUT;
                            o_ctl.char_pos = '0;
                        end else begin
                            o_ctl.phase = PH_BAD;
                        end
                    end else if (i_byte == kw_set_char(i_ctl.char_pos)) begin
                        o_ctl.char_pos = i_ctl.char_pos + 3'd1;
                    end else begin
                        o_ctl.phase = PH_BAD;
                    end
                end
                PH_TIMEOUT: begin
                    if (i_ctl.char_pos >= TIMEOUT_LEN) begin
                        if (i_byte == CH_BAR) begin
                            o_ctl.phase    = PH_DIGITS;
                            o_ctl.char_pos = '0;
                        end else begin
                            o_ctl.phase = PH_BAD;
                        end
                    end else if (i_byte == kw_timeout_char(i_ctl.char_pos)) begin
                        o_ctl.char_pos = i_ctl.char_pos + 3'd1;
                    end else begin
                        o_ctl.phase = PH_BAD;
                    end
                end
                PH_DIGITS: begin
                    if (w_is_digit) begin
                        if (|w_prod[EXT_W-1:VALUE_BITS]) begin
                            o_accum = '1;
                        end else begin
                            o_accum = w_prod[VALUE_BITS-1:0];
                        end
                    end else if (i_byte == CH_CR) begin
                        o_ctl.phase = PH_LF;
                    end else begin
                        o_ctl.phase = PH_BAD;
                    end
                end
                PH_LF: begin
                    o_ctl.phase = (i_byte == CH_LF) ? PH_DONE : PH_BAD;
                end
                default: begin
                    // finished, invalid and unused codes hold
                end
            endcase
        end
    end

    // reported value is clipped to the output field
    generate
        if (VALUE_BITS > OUT_VALUE_W) begin : g_clip
            assign o_value = (|o_accum[VALUE_BITS-1:OUT_VALUE_W]) ? '1
                                                                  : o_accum[OUT_VALUE_W-1:0];
        end else if (VALUE_BITS == OUT_VALUE_W) begin : g_same
            assign o_value = o_accum;
        end else begin : g_ext
            assign o_value = {{(OUT_VALUE_W-VALUE_BITS){1'b0}}, o_accum};
        end
    endgenerate

endmodule

### design/timeout_command_parser_unit.sv
// Timeout command parser: takes one byte of the line SET|TIMEOUT|<digits> CR LF per word
// on i_in and returns one status word (phase, value so far, done flag) per byte on o_out.
// While i_in.ready is high a byte is accepted every cycle and its status is registered
// in the output register; i_in.ready drops only while it is full and o_out.ready is low.
// The parser state and the output register are updated in the same cycle the byte is
// taken. restart returns the parser to the start of the line and ignores the byte.
// The decimal accumulator is VALUE_BITS wide and saturates; the reported value is
// clipped to 32 bits.
module timeout_command_parser_unit #(
    parameter int VALUE_BITS = tcp_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcp_in_if.sink     i_in,
    tcp_out_if.source  o_out
);
    import tcp_pkg::*;

    t_ctl                    r_ctl;
    logic [VALUE_BITS-1:0]   r_accum;
    logic                    r_out_valid;
    t_phase                  r_out_phase;
    logic [OUT_VALUE_W-1:0]  r_out_value;
    logic                    r_out_done;

    t_ctl                    n_ctl;
    logic [VALUE_BITS-1:0]   n_accum;
    logic [OUT_VALUE_W-1:0]  n_value;

    logic                    w_in_ready;
    logic                    w_in_acc;

    tcp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_ctl     (r_ctl),
        .i_accum   (r_accum),
        .i_byte    (i_in.byte_in),
        .i_restart (i_in.restart),
        .o_ctl     (n_ctl),
        .o_accum   (n_accum),
        .o_value   (n_value)
    );

    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase    <= PH_SET;
            r_ctl.char_pos <= '0;
            r_accum        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_ctl       <= n_ctl;
                r_accum     <= n_accum;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_phase <= n_ctl.phase;
            r_out_value <= n_value;
            r_out_done  <= (n_ctl.phase >= PH_DONE);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.phase         = r_out_phase;
    assign o_out.timeout_value = r_out_value;
    assign o_out.done_res      = r_out_done;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.restart) |=>
            (r_out_valid && r_out_phase == PH_SET && r_out_value == '0 && !r_out_done))
        else $error("restart did not return parser to start");

    a_final_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in.restart && (r_ctl.phase == PH_DONE || r_ctl.phase == PH_BAD))
            |=> (r_ctl.phase == $past(r_ctl.phase) && r_accum == $past(r_accum)))
        else $error("finished or invalid phase changed without restart");

    a_done_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_done == (r_out_phase == PH_DONE || r_out_phase == PH_BAD)))
        else $error("done flag disagrees with phase");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while output register empty");

endmodule
